/* rtl/core/bmoi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmoi_pkg
// Shared types and constants of the binary mask overlap index block.
// ----------------------------------------------------------------------------
package bmoi_pkg;

  // largest volume that the counters track before they saturate
  localparam longint unsigned MaxVoxels = 64'd16777216;

  localparam int CntW = 25;
  localparam int DivW = 26;
  localparam int IdxW = 17;

  localparam longint unsigned CntMax = (64'd1 << CntW) - 64'd1;
  localparam logic [CntW-1:0] CntCap = CntW'((MaxVoxels < CntMax) ? MaxVoxels : CntMax);

  // one integer bit and sixteen fraction bits of quotient
  localparam int DivSteps = IdxW;
  localparam int IterW    = $clog2(DivSteps);

  localparam logic [IterW-1:0] IterLast = IterW'(DivSteps - 1);

  // index mode register values
  typedef enum logic {
    ModeJaccard = 1'b0,
    ModeDice    = 1'b1
  } index_mode_e;

  // input word: one voxel pair
  typedef struct packed {
    logic [7:0] voxel_a;
    logic [7:0] voxel_b;
    logic       last_voxel;
  } voxel_in_t;

  // output word: one result per volume
  typedef struct packed {
    logic [IdxW-1:0] overlap_index;
    logic [CntW-1:0] both_count;
    logic [DivW-1:0] divisor_count;
  } overlap_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic count;
    logic load;
    logic step;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

/* rtl/core/bmoi_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmoi_datapath
// Membership counters, mode register, radix-2 restoring divider and the
// output word register.
// ----------------------------------------------------------------------------
module bmoi_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  input  bmoi_pkg::voxel_in_t   in_word_i,
  input  bmoi_pkg::dp_cmd_t     cmd_i,
  output bmoi_pkg::dp_sts_t     sts_o,
  output bmoi_pkg::overlap_out_t out_word_o
);

  logic                          mode_q;
  logic [bmoi_pkg::CntW-1:0]     cnt_a_q, cnt_b_q, cnt_both_q;
  logic [bmoi_pkg::CntW-1:0]     cnt_a_d, cnt_b_d, cnt_both_d;
  logic [bmoi_pkg::CntW-1:0]     both_q;
  logic [bmoi_pkg::DivW-1:0]     div_q, rem_q, rem_d;
  logic [bmoi_pkg::IdxW-1:0]     quo_q;
  logic [bmoi_pkg::IterW-1:0]    iter_q;
  logic [bmoi_pkg::DivW-1:0]     sum;
  logic [bmoi_pkg::DivW:0]       trial;
  logic [bmoi_pkg::DivW:0]       diff;
  logic                          ge;
  logic                          in_a, in_b;
  bmoi_pkg::overlap_out_t        out_q;

  assign in_a = (in_word_i.voxel_a != 8'd0);
  assign in_b = (in_word_i.voxel_b != 8'd0);

  // saturating counter update
  function automatic logic [bmoi_pkg::CntW-1:0] bump(input logic [bmoi_pkg::CntW-1:0] c);
    bump = (c < bmoi_pkg::CntCap) ? c + bmoi_pkg::CntW'(1) : bmoi_pkg::CntCap;
  endfunction

  always_comb begin
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    cnt_both_d = cnt_both_q;
    if (cmd_i.load) begin
      cnt_a_d    = '0;
      cnt_b_d    = '0;
      cnt_both_d = '0;
    end else if (cmd_i.count) begin
      if (in_a) cnt_a_d = bump(cnt_a_q);
      if (in_b) cnt_b_d = bump(cnt_b_q);
      if (in_a && in_b) cnt_both_d = bump(cnt_both_q);
    end
  end

  // mode register and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      cnt_both_q <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_data_i;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
      cnt_both_q <= cnt_both_d;
    end
  end

  assign sum = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};

  // divider step: first step takes the integer bit, the rest shift in zeros
  assign trial = (iter_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});
  assign rem_d = ge ? diff[bmoi_pkg::DivW-1:0] : trial[bmoi_pkg::DivW-1:0];

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.load) begin
      iter_q <= '0;
    end else if (cmd_i.step) begin
      iter_q <= iter_q + bmoi_pkg::IterW'(1);
    end
  end

  // divider operands and quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      both_q <= cnt_both_q;
      quo_q  <= '0;
      if (mode_q) begin
        div_q <= sum;
        rem_q <= {cnt_both_q, 1'b0};
      end else begin
        div_q <= sum - {1'b0, cnt_both_q};
        rem_q <= {1'b0, cnt_both_q};
      end
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[bmoi_pkg::IdxW-2:0], ge};
    end
  end

  // output word register, empty divisor gives zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.overlap_index <= (div_q == '0) ? '0 : quo_q;
      out_q.both_count    <= both_q;
      out_q.divisor_count <= div_q;
    end
  end

  assign out_word_o     = out_q;
  assign sts_o.div_last = (iter_q == bmoi_pkg::IterLast);

endmodule

/* rtl/core/bmoi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmoi_ctrl
// Controller: counts words, runs the divider after the last word and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module bmoi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  bmoi_pkg::dp_sts_t  sts_i,
  output bmoi_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StRun,
    StLoad,
    StDiv,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_ready_o = (state_q == StRun);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o        = '0;
    case (state_q)
      StRun: begin
        cmd_o.count = in_acc;
        if (in_acc && in_last_i) state_d = StLoad;
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StRun;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // a last word closes the input until the result is handed off
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> !in_ready_o)
    else $error("input open after last word");

  // the output register is never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result overwritten before it was taken");

  // divider load and step never coincide
  a_load_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.step))
    else $error("divider load and step together");

  // load is always followed by divide steps
  a_load_then_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.step)
    else $error("divider load without steps");

endmodule

/* rtl/core/binary_mask_overlap_index.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_overlap_index
// Jaccard or Dice overlap of two binary masks streamed as voxel pairs.
// ----------------------------------------------------------------------------
// Voxel pairs are taken one word per cycle while the volume streams. The
// word marked last is counted and then closes the input while the block
// loads the divider, runs the radix-2 restoring divider (one quotient bit
// per cycle) and hands the result to the output register, after any wait
// for the previous result to be taken. The result is Q1.16 (65536 is 1.0),
// truncated, 0 when the divisor is zero; index_mode 0 selects Jaccard, 1
// selects Dice. The user must write it only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module binary_mask_overlap_index (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bmoi_pkg::voxel_in_t    in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bmoi_pkg::overlap_out_t out_word_o
);

  bmoi_pkg::dp_cmd_t cmd;
  bmoi_pkg::dp_sts_t sts;

  // mode register always takes a write
  assign cfg_ready_o = 1'b1;

  // controller
  bmoi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_word_i.last_voxel),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  bmoi_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
